@@ sv/tdrbc_pkg.sv @@
// Shared types, codes and constants for the two-direction relay blind controller.
package tdrbc_pkg;

  localparam int BLIND_COUNT = 5;

  localparam int RELAY_W = 5;
  localparam int POSW_W  = 10;
  localparam int CNT_W   = 8;
  localparam int OPC_W   = 3;
  localparam int IDX_W   = 4;
  localparam int DIR_W   = 2;
  localparam int PCODE_W = 2;

  localparam logic [RELAY_W-1:0] BLIND_MASK = RELAY_W'((1 << BLIND_COUNT) - 1);
  localparam logic [CNT_W-1:0]   MOVE_TIME_RST = CNT_W'(10);

  typedef logic [OPC_W-1:0]   opcode_t;
  typedef logic [DIR_W-1:0]   dir_t;
  typedef logic [PCODE_W-1:0] pcode_t;

  localparam opcode_t OP_TICK     = 3'd0;
  localparam opcode_t OP_ALL_UP   = 3'd1;
  localparam opcode_t OP_ALL_DOWN = 3'd2;
  localparam opcode_t OP_STOP_ALL = 3'd3;
  localparam opcode_t OP_SINGLE   = 3'd4;

  localparam dir_t DIR_DOWN    = 2'd0;
  localparam dir_t DIR_UP      = 2'd1;
  localparam dir_t DIR_STOP    = 2'd2;
  localparam dir_t DIR_INVALID = 2'd3;

  localparam pcode_t POS_UNKNOWN = 2'd0;
  localparam pcode_t POS_UP      = 2'd1;
  localparam pcode_t POS_DOWN    = 2'd2;
  localparam pcode_t POS_MID     = 2'd3;

  typedef struct packed {
    opcode_t          opcode;
    logic [IDX_W-1:0] blind_index;
    dir_t             direction;
  } item_t;

  typedef struct packed {
    logic [RELAY_W-1:0] up_relays;
    logic [RELAY_W-1:0] down_relays;
    logic [POSW_W-1:0]  blind_positions;
    logic               timer_active;
    logic [CNT_W-1:0]   seconds_remaining;
  } result_t;

  // Pipeline handshake between input and result stages
  typedef struct packed {
    logic take;   // input register hands its beat to the core this cycle
    logic free;   // result register can load this cycle
  } flow_t;

endpackage

@@ sv/tdrbc_in_if.sv @@
// Command channel interface: valid/ready plus one command beat.
interface tdrbc_in_if import tdrbc_pkg::*; ();
  logic             valid;
  logic             ready;
  opcode_t          opcode;
  logic [IDX_W-1:0] blind_index;
  dir_t             direction;

  modport source (output valid, output opcode, output blind_index, output direction,
                  input ready);
  modport sink   (input valid, input opcode, input blind_index, input direction,
                  output ready);
endinterface

@@ sv/tdrbc_out_if.sv @@
// Status channel interface: valid/ready plus one status beat.
interface tdrbc_out_if import tdrbc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RELAY_W-1:0] up_relays;
  logic [RELAY_W-1:0] down_relays;
  logic [POSW_W-1:0]  blind_positions;
  logic               timer_active;
  logic [CNT_W-1:0]   seconds_remaining;

  modport source (output valid, output up_relays, output down_relays,
                  output blind_positions, output timer_active, output seconds_remaining,
                  input ready);
  modport sink   (input valid, input up_relays, input down_relays,
                  input blind_positions, input timer_active, input seconds_remaining,
                  output ready);
endinterface

@@ sv/tdrbc_in_stage.sv @@
// Input register: captures one command beat and hands it to the core.
module tdrbc_in_stage import tdrbc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  tdrbc_in_if.sink      in_ch,
  input  logic          out_free,
  output flow_t         flow,
  output item_t         item
);

  logic  vld_r;
  item_t item_r;
  logic  take;

  assign take         = vld_r && out_free;
  assign in_ch.ready  = !vld_r || take;
  assign flow.take    = take;
  assign flow.free    = out_free;
  assign item         = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.opcode      <= in_ch.opcode;
      item_r.blind_index <= in_ch.blind_index;
      item_r.direction   <= in_ch.direction;
    end
  end

endmodule

@@ sv/tdrbc_core.sv @@
// Blind state, countdown and move-time register with next-state logic for one command.
module tdrbc_core import tdrbc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  flow_t            flow,
  input  item_t            item,
  output result_t          res_nxt
);

  logic [CNT_W-1:0]   move_time_r;
  logic [RELAY_W-1:0] up_r, up_nxt;
  logic [RELAY_W-1:0] dn_r, dn_nxt;
  pcode_t             pos_r   [BLIND_COUNT];
  pcode_t             pos_nxt [BLIND_COUNT];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               run_r, run_nxt;

  logic [CNT_W-1:0]   cnt_dec;
  logic [RELAY_W-1:0] sel;
  logic               do_release;
  logic [POSW_W-1:0]  posword;

  assign cnt_dec = cnt_r - CNT_W'(1);

  // one-hot select of the addressed blind; empty when the index is out of range
  always_comb begin
    sel = '0;
    for (int i = 0; i < BLIND_COUNT; i++) begin
      sel[i] = (item.blind_index == IDX_W'(i + 1));
    end
  end

  always_comb begin
    up_nxt     = up_r;
    dn_nxt     = dn_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    do_release = 1'b0;

    case (item.opcode)
      OP_TICK: begin
        if (run_r) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            for (int i = 0; i < BLIND_COUNT; i++) begin
              if (up_r[i]) pos_nxt[i] = POS_UP;
              if (dn_r[i]) pos_nxt[i] = POS_DOWN;
            end
            up_nxt  = '0;
            dn_nxt  = '0;
            run_nxt = 1'b0;
          end
        end
      end
      OP_ALL_UP: begin
        if (|(dn_r & BLIND_MASK)) begin
          do_release = 1'b1;
        end else begin
          up_nxt  = BLIND_MASK;
          cnt_nxt = move_time_r;
          run_nxt = 1'b1;
        end
      end
      OP_ALL_DOWN: begin
        if (|(up_r & BLIND_MASK)) begin
          do_release = 1'b1;
        end else begin
          dn_nxt  = BLIND_MASK;
          cnt_nxt = move_time_r;
          run_nxt = 1'b1;
        end
      end
      OP_STOP_ALL: begin
        run_nxt    = 1'b0;
        do_release = 1'b1;
      end
      OP_SINGLE: begin
        if (item.direction == DIR_INVALID || !(|sel)) begin
          do_release = 1'b1;
        end else if (item.direction == DIR_DOWN) begin
          if (|(up_r & sel)) begin
            up_nxt = up_r & ~sel;
          end else begin
            dn_nxt  = dn_r | sel;
            cnt_nxt = move_time_r;
            run_nxt = 1'b1;
          end
        end else if (item.direction == DIR_UP) begin
          if (|(dn_r & sel)) begin
            dn_nxt = dn_r & ~sel;
          end else begin
            up_nxt  = up_r | sel;
            cnt_nxt = move_time_r;
            run_nxt = 1'b1;
          end
        end else begin
          up_nxt = up_r & ~sel;
          dn_nxt = dn_r & ~sel;
          for (int i = 0; i < BLIND_COUNT; i++) begin
            if (sel[i]) pos_nxt[i] = POS_MID;
          end
        end
      end
      default: begin
      end
    endcase

    // release: moving blinds become midway, all relays off, countdown untouched
    if (do_release) begin
      for (int i = 0; i < BLIND_COUNT; i++) begin
        if (up_r[i] || dn_r[i]) pos_nxt[i] = POS_MID;
      end
      up_nxt = '0;
      dn_nxt = '0;
    end
  end

  always_comb begin
    posword = '0;
    for (int i = 0; i < BLIND_COUNT; i++) begin
      posword[2*i +: PCODE_W] = pos_nxt[i];
    end
  end

  assign res_nxt.up_relays         = up_nxt & BLIND_MASK;
  assign res_nxt.down_relays       = dn_nxt & BLIND_MASK;
  assign res_nxt.blind_positions   = posword;
  assign res_nxt.timer_active      = run_nxt;
  assign res_nxt.seconds_remaining = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_time_r <= MOVE_TIME_RST;
    end else if (cfg_we) begin
      move_time_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r  <= '0;
      dn_r  <= '0;
      cnt_r <= '0;
      run_r <= 1'b0;
      for (int i = 0; i < BLIND_COUNT; i++) begin
        pos_r[i] <= POS_UNKNOWN;
      end
    end else if (flow.take) begin
      up_r  <= up_nxt;
      dn_r  <= dn_nxt;
      cnt_r <= cnt_nxt;
      run_r <= run_nxt;
      pos_r <= pos_nxt;
    end
  end

  // a blind never has both relays on
  a_no_conflict: assert property (@(posedge clk) disable iff (!rst_n)
    (up_r & dn_r) == '0)
    else $error("blind with both relays energized");

  // any energized relay implies a running countdown
  a_relay_needs_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (|(up_r | dn_r)) |-> run_r)
    else $error("relay on with countdown stopped");

  // the last tick stops the countdown and drops every relay
  a_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    (flow.take && item.opcode == OP_TICK && run_r && cnt_r == CNT_W'(1))
      |=> (!run_r && up_r == '0 && dn_r == '0))
    else $error("countdown expiry did not clear state");

endmodule

@@ sv/tdrbc_out_stage.sv @@
// Result register: holds one status beat until the sink takes it.
module tdrbc_out_stage import tdrbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  flow_t     flow,
  input  result_t   res_nxt,
  output logic      out_free,
  tdrbc_out_if.source out_ch
);

  logic    vld_r;
  result_t res_r;

  assign out_free = !vld_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (flow.free) begin
      vld_r <= flow.take;
    end
  end

  always_ff @(posedge clk) begin
    if (flow.take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = vld_r;
  assign out_ch.up_relays         = res_r.up_relays;
  assign out_ch.down_relays       = res_r.down_relays;
  assign out_ch.blind_positions   = res_r.blind_positions;
  assign out_ch.timer_active      = res_r.timer_active;
  assign out_ch.seconds_remaining = res_r.seconds_remaining;

endmodule

@@ sv/two_direction_relay_blind_controller.sv @@
// Top level of the two-direction relay blind controller.
// Controls the up and down relays of five blinds. Each command beat (second tick,
// all up, all down, stop all, or a single-blind command) yields exactly one status
// beat showing relays, positions and countdown after that command. A command beat
// is held in the input register until the result register is free, and its status
// beat is then loaded into the result register, which drives the status channel;
// one beat is accepted every cycle while the status sink keeps up.
// cfg_we/cfg_wdata set the move time in seconds (reset 10); write it only while
// no command is in flight. A move time of zero runs for 256 ticks.
module two_direction_relay_blind_controller import tdrbc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  tdrbc_in_if.sink         in_ch,
  tdrbc_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  flow_t   flow;
  item_t   item;
  result_t res_nxt;
  logic    out_free;

  tdrbc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .flow     (flow),
    .item     (item)
  );

  tdrbc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .flow      (flow),
    .item      (item),
    .res_nxt   (res_nxt)
  );

  tdrbc_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .flow     (flow),
    .res_nxt  (res_nxt),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule
